@@ sv/tlj_pkg.sv @@
`timescale 1ns / 1ps
// Package for the two-link joint solver: payload structs, pipeline context,
// cell data types and the per-cell step functions. No dependencies.
package tlj_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int SQRT_STEPS      = 25;
    localparam int XQ_STEPS        = 31;
    localparam int OUT_STEPS       = 16;

    typedef struct packed {
        logic signed [15:0] upper_x;
        logic signed [15:0] upper_y;
        logic signed [15:0] lower_x;
        logic signed [15:0] lower_y;
        logic        [15:0] upper_len;
        logic        [15:0] lower_len;
    } t_in;

    typedef struct packed {
        logic signed [15:0] joint_dx;
        logic signed [15:0] joint_dy;
        logic               unreachable;
    } t_out;

    typedef struct packed {
        logic               unreach;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic        [47:0] aq2;
        logic signed [35:0] n;
        logic        [24:0] dq;
        logic               negn;
        logic               ovfn;
        logic        [30:0] xmag;
        logic signed [31:0] xq;
        logic signed [48:0] dxxq;
        logic signed [48:0] dyxq;
        logic               negx;
        logic               negy;
        logic               ovfx;
        logic               ovfy;
    } t_ctx;

    typedef struct packed {
        logic [49:0] v;
        logic [49:0] res;
        logic [49:0] bitw;
    } t_sqrt;

    typedef struct packed {
        logic [55:0] rem;
        logic [55:0] dvs;
        logic [30:0] q;
    } t_div_lane;

    typedef struct packed {
        t_div_lane l0;
        t_div_lane l1;
    } t_div_pair;

    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt      r;
        logic [50:0] trial;
        r     = s;
        trial = {1'b0, s.res} + {1'b0, s.bitw};
        if ({1'b0, s.v} >= trial) begin
            r.v   = s.v - trial[49:0];
            r.res = (s.res >> 1) + s.bitw;
        end else begin
            r.res = s.res >> 1;
        end
        r.bitw = s.bitw >> 2;
        return r;
    endfunction

    function automatic t_div_lane div_step(input t_div_lane s);
        t_div_lane r;
        r = s;
        if (s.rem >= s.dvs) begin
            r.rem = s.rem - s.dvs;
            r.q   = {s.q[29:0], 1'b1};
        end else begin
            r.q   = {s.q[29:0], 1'b0};
        end
        r.dvs = s.dvs >> 1;
        return r;
    endfunction

endpackage

@@ sv/two_link_joint_solver.sv @@
`timescale 1ns / 1ps
// Top level of the two-link joint solver: entry stages, two square-root chains,
// two divider chains and the output register. Depends on tlj_pkg and the cells.
//
// Takes one item per clock while the pipe is not held and returns one result per
// item, in order. Every stage and every cell of the chains advances together;
// the whole pipe holds only while the output register keeps a result that has
// not been transferred, so throughput is set by the output side alone.
module two_link_joint_solver
    import tlj_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);
    localparam int SH2 = 2 * COORD_FRAC_BITS;

    logic en;
    logic r_out_valid;
    t_out r_out;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // entry stages
    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [16:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic        [15:0] r_a1, r_b1;
    logic        [33:0] r_dxsq, r_dysq;
    logic        [31:0] r_asq, r_bsq, r_asq3;
    logic        [16:0] r_sum;
    logic        [15:0] r_dif;
    logic        [33:0] r_d2, r_sum2;
    logic        [31:0] r_dif2;
    logic signed [32:0] r_ab;
    t_ctx               r_c4;
    t_ctx               n_c4;
    t_sqrt              r_sq4;

    logic signed [33:0] dx_sq, dy_sq;
    assign dx_sq = r_dx1 * r_dx1;
    assign dy_sq = r_dy1 * r_dy1;

    always_comb begin
        n_c4         = '0;
        n_c4.unreach = (r_d2 == '0) || (r_d2 > r_sum2) || (r_d2 < {2'b0, r_dif2});
        n_c4.dx      = r_dx3;
        n_c4.dy      = r_dy3;
        n_c4.aq2     = 48'({r_asq3, SH2'(0)});
        n_c4.n       = 36'(r_ab) + signed'({2'b0, r_d2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1  <= 17'(i_in_data.lower_x) - 17'(i_in_data.upper_x);
            r_dy1  <= 17'(i_in_data.lower_y) - 17'(i_in_data.upper_y);
            r_a1   <= i_in_data.upper_len;
            r_b1   <= i_in_data.lower_len;
            r_dxsq <= unsigned'(dx_sq);
            r_dysq <= unsigned'(dy_sq);
            r_asq  <= r_a1 * r_a1;
            r_bsq  <= r_b1 * r_b1;
            r_sum  <= {1'b0, r_a1} + {1'b0, r_b1};
            r_dif  <= (r_a1 > r_b1) ? r_a1 - r_b1 : r_b1 - r_a1;
            r_dx2  <= r_dx1;
            r_dy2  <= r_dy1;
            r_d2   <= r_dxsq + r_dysq;
            r_sum2 <= r_sum * r_sum;
            r_dif2 <= r_dif * r_dif;
            r_ab   <= signed'({1'b0, r_asq}) - signed'({1'b0, r_bsq});
            r_asq3 <= r_asq;
            r_dx3  <= r_dx2;
            r_dy3  <= r_dy2;
            r_c4   <= n_c4;
            r_sq4  <= '{v: 50'({r_d2, SH2'(0)}), res: '0, bitw: 50'(1) << 48};
        end
    end

    // distance square root chain
    logic  s1_v    [SQRT_STEPS+1];
    t_ctx  s1_c    [SQRT_STEPS+1];
    t_sqrt s1_d    [SQRT_STEPS+1];
    assign s1_v[0] = r_v4;
    assign s1_c[0] = r_c4;
    assign s1_d[0] = r_sq4;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq1
        tlj_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(s1_v[k]), .i_ctx(s1_c[k]), .i_data(s1_d[k]),
            .o_valid(s1_v[k+1]), .o_ctx(s1_c[k+1]), .o_data(s1_d[k+1])
        );
    end

    // base: rounded division of the projection numerator by the distance
    logic        r_v5, r_v6, r_v7;
    t_ctx        r_c5, r_c6, r_c7;
    t_ctx        n_c5, n_c7;
    logic [34:0] r_magn;
    logic [50:0] r_numn;
    t_div_pair   r_dv7;

    always_comb begin
        n_c5      = s1_c[SQRT_STEPS];
        n_c5.dq   = s1_d[SQRT_STEPS].res[24:0];
        n_c5.negn = s1_c[SQRT_STEPS].n[35];
        n_c7      = r_c6;
        n_c7.ovfn = {5'b0, r_numn} >= 56'({r_c6.dq, 31'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v5 <= s1_v[SQRT_STEPS];
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c5      <= n_c5;
            r_magn    <= s1_c[SQRT_STEPS].n[35] ? 35'(-s1_c[SQRT_STEPS].n)
                                                : 35'(s1_c[SQRT_STEPS].n);
            r_c6      <= r_c5;
            r_numn    <= 51'({r_magn, 15'b0}) + 51'(r_c5.dq >> 1);
            r_c7      <= n_c7;
            r_dv7     <= '{l0: '{rem: 56'(r_numn), dvs: 56'({r_c6.dq, 30'b0}), q: '0},
                           l1: '0};
        end
    end

    logic      d1_v [XQ_STEPS+1];
    t_ctx      d1_c [XQ_STEPS+1];
    t_div_pair d1_d [XQ_STEPS+1];
    assign d1_v[0] = r_v7;
    assign d1_c[0] = r_c7;
    assign d1_d[0] = r_dv7;

    for (genvar k = 0; k < XQ_STEPS; k++) begin : g_dv1
        tlj_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(d1_v[k]), .i_ctx(d1_c[k]), .i_data(d1_d[k]),
            .o_valid(d1_v[k+1]), .o_ctx(d1_c[k+1]), .o_data(d1_d[k+1])
        );
    end

    // height: clamp the base, square it, subtract from the first segment squared
    localparam logic [30:0] XQ_LIM = 31'(1) << 30;
    logic        r_v8, r_v9, r_v10;
    t_ctx        r_c8, r_c9, r_c10;
    t_ctx        n_c8, n_c9;
    logic [61:0] r_xq2;
    t_sqrt       r_sq10;
    logic [30:0] qx;
    logic [30:0] xmag;

    assign qx   = d1_d[XQ_STEPS].l0.q;
    assign xmag = (d1_c[XQ_STEPS].ovfn || qx > XQ_LIM) ? XQ_LIM : qx;

    always_comb begin
        n_c8      = d1_c[XQ_STEPS];
        n_c8.xmag = xmag;
        n_c8.xq   = d1_c[XQ_STEPS].negn ? -signed'({1'b0, xmag}) : signed'({1'b0, xmag});
        n_c9      = r_c8;
        n_c9.dxxq = r_c8.dx * r_c8.xq;
        n_c9.dyxq = r_c8.dy * r_c8.xq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v8  <= d1_v[XQ_STEPS];
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c8      <= n_c8;
            r_c9      <= n_c9;
            r_xq2     <= r_c8.xmag * r_c8.xmag;
            r_c10     <= r_c9;
            r_sq10    <= '{v: (r_xq2 >= {14'b0, r_c9.aq2}) ? '0
                                                          : 50'(r_c9.aq2 - r_xq2[47:0]),
                           res: '0,
                           bitw: 50'(1) << 48};
        end
    end

    logic  s2_v [SQRT_STEPS+1];
    t_ctx  s2_c [SQRT_STEPS+1];
    t_sqrt s2_d [SQRT_STEPS+1];
    assign s2_v[0] = r_v10;
    assign s2_c[0] = r_c10;
    assign s2_d[0] = r_sq10;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq2
        tlj_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(s2_v[k]), .i_ctx(s2_c[k]), .i_data(s2_d[k]),
            .o_valid(s2_v[k+1]), .o_ctx(s2_c[k+1]), .o_data(s2_d[k+1])
        );
    end

    // rotate by the line direction and divide both offsets by the distance
    logic               r_v11, r_v12, r_v13, r_v14, r_v15;
    t_ctx               r_c11, r_c12, r_c13, r_c14, r_c15;
    t_ctx               n_c13, n_c15;
    logic signed [42:0] r_dyhq, r_dxhq;
    logic signed [49:0] r_numx, r_numy;
    logic        [49:0] r_magx, r_magy;
    logic        [50:0] r_rndx, r_rndy;
    t_div_pair          r_dv15;
    logic signed [25:0] hq;

    assign hq = signed'({1'b0, s2_d[SQRT_STEPS].res[24:0]});

    always_comb begin
        n_c13      = r_c12;
        n_c13.negx = r_numx[49];
        n_c13.negy = r_numy[49];
        n_c15      = r_c14;
        n_c15.ovfx = {5'b0, r_rndx} >= 56'({r_c14.dq, 16'b0});
        n_c15.ovfy = {5'b0, r_rndy} >= 56'({r_c14.dq, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
            r_v13 <= 1'b0;
            r_v14 <= 1'b0;
            r_v15 <= 1'b0;
        end else if (en) begin
            r_v11 <= s2_v[SQRT_STEPS];
            r_v12 <= r_v11;
            r_v13 <= r_v12;
            r_v14 <= r_v13;
            r_v15 <= r_v14;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c11  <= s2_c[SQRT_STEPS];
            r_dyhq <= s2_c[SQRT_STEPS].dy * hq;
            r_dxhq <= s2_c[SQRT_STEPS].dx * hq;
            r_c12  <= r_c11;
            r_numx <= 50'(r_c11.dxxq) - 50'(r_dyhq);
            r_numy <= 50'(r_c11.dyxq) + 50'(r_dxhq);
            r_c13      <= n_c13;
            r_magx     <= r_numx[49] ? unsigned'(-r_numx) : unsigned'(r_numx);
            r_magy     <= r_numy[49] ? unsigned'(-r_numy) : unsigned'(r_numy);
            r_c14  <= r_c13;
            r_rndx <= {1'b0, r_magx} + 51'(r_c13.dq >> 1);
            r_rndy <= {1'b0, r_magy} + 51'(r_c13.dq >> 1);
            r_c15      <= n_c15;
            r_dv15     <= '{l0: '{rem: 56'(r_rndx), dvs: 56'({r_c14.dq, 15'b0}), q: '0},
                            l1: '{rem: 56'(r_rndy), dvs: 56'({r_c14.dq, 15'b0}), q: '0}};
        end
    end

    logic      d2_v [OUT_STEPS+1];
    t_ctx      d2_c [OUT_STEPS+1];
    t_div_pair d2_d [OUT_STEPS+1];
    assign d2_v[0] = r_v15;
    assign d2_c[0] = r_c15;
    assign d2_d[0] = r_dv15;

    for (genvar k = 0; k < OUT_STEPS; k++) begin : g_dv2
        tlj_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(d2_v[k]), .i_ctx(d2_c[k]), .i_data(d2_d[k]),
            .o_valid(d2_v[k+1]), .o_ctx(d2_c[k+1]), .o_data(d2_d[k+1])
        );
    end

    // saturate and drop the offsets of an unreachable pose
    localparam logic [15:0] POS_MAX = 16'h7FFF;
    localparam logic [15:0] NEG_MAX = 16'h8000;
    t_ctx        fc;
    logic [15:0] qox, qoy;
    logic [15:0] n_jx, n_jy;

    assign fc  = d2_c[OUT_STEPS];
    assign qox = d2_d[OUT_STEPS].l0.q[15:0];
    assign qoy = d2_d[OUT_STEPS].l1.q[15:0];

    always_comb begin
        if (fc.negx) begin
            n_jx = (fc.ovfx || qox > NEG_MAX) ? NEG_MAX : 16'(-qox);
        end else begin
            n_jx = (fc.ovfx || qox > POS_MAX) ? POS_MAX : qox;
        end
        if (fc.negy) begin
            n_jy = (fc.ovfy || qoy > NEG_MAX) ? NEG_MAX : 16'(-qoy);
        end else begin
            n_jy = (fc.ovfy || qoy > POS_MAX) ? POS_MAX : qoy;
        end
        if (fc.unreach) begin
            n_jx = '0;
            n_jy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_v[OUT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= '{joint_dx: signed'(n_jx), joint_dy: signed'(n_jy),
                       unreachable: fc.unreach};
        end
    end
endmodule

@@ sv/tlj_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One cell of the square-root chain: one result bit per cell, context riding along.
// Depends on tlj_pkg.
module tlj_sqrt_cell
    import tlj_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_ctx  i_ctx,
    input  t_sqrt i_data,
    output logic  o_valid,
    output t_ctx  o_ctx,
    output t_sqrt o_data
);
    logic  r_valid;
    t_ctx  r_ctx;
    t_sqrt r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx  <= i_ctx;
            r_data <= sqrt_step(i_data);
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_data  = r_data;
endmodule

@@ sv/tlj_div_cell.sv @@
`timescale 1ns / 1ps
// One cell of the restoring divider chain: two lanes, one quotient bit each.
// Depends on tlj_pkg.
module tlj_div_cell
    import tlj_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_ctx      i_ctx,
    input  t_div_pair i_data,
    output logic      o_valid,
    output t_ctx      o_ctx,
    output t_div_pair o_data
);
    logic      r_valid;
    t_ctx      r_ctx;
    t_div_pair r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx     <= i_ctx;
            r_data.l0 <= div_step(i_data.l0);
            r_data.l1 <= div_step(i_data.l1);
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_data  = r_data;
endmodule

@@ dv/tb_two_link_joint_solver.sv @@
`timescale 1ns / 1ps
// Testbench for two_link_joint_solver: random and directed limb geometries
// checked against an in-bench fixed-point joint predictor. Depends on tlj_pkg.
module tb_two_link_joint_solver;
    import tlj_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_out joint_queue[$];
    int   mismatches = 0;
    int   stall_mode = 0;
    bit   sink_run = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    two_link_joint_solver u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_out solve_joint(input t_in it);
        t_out r;
        longint dx, dy, a, b, d2, sum, dif, dq, n, xq, aq2, xq2, hq;
        dx = longint'(it.lower_x) - longint'(it.upper_x);
        dy = longint'(it.lower_y) - longint'(it.upper_y);
        a = longint'({1'b0, it.upper_len});
        b = longint'({1'b0, it.lower_len});
        d2 = dx * dx + dy * dy;
        sum = a + b;
        dif = (a > b) ? a - b : b - a;
        r = '0;
        if (d2 == 0 || d2 > sum * sum || d2 < dif * dif) begin
            r.unreachable = 1'b1;
            return r;
        end
        dq = longint'(int_sqrt(longint'(d2) << 16));
        n = a * a - b * b + d2;
        xq = round_div(n * 32768, dq);
        if (xq > (64'sd1 <<< 30)) xq = 64'sd1 <<< 30;
        if (xq < -(64'sd1 <<< 30)) xq = -(64'sd1 <<< 30);
        aq2 = (a * 256) * (a * 256);
        xq2 = xq * xq;
        hq = (xq2 >= aq2) ? 0 : longint'(int_sqrt(aq2 - xq2));
        r.joint_dx = clamp16(round_div(dx * xq - dy * hq, dq));
        r.joint_dy = clamp16(round_div(dy * xq + dx * hq, dq));
        return r;
    endfunction

    task automatic send_item(input t_in it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        joint_queue.push_back(solve_joint(it));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Bursty sender: gap only between bursts.
    int burst_left = 0;
    task automatic send_paced(input t_in it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        send_item(it);
    endtask

    always @(posedge i_clk) begin
        int c;
        c = $urandom_range(0, 99);
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= (c < 70);
            2: i_out_ready <= (c < 20);
            default: i_out_ready <= ((c % 8) < 4);
        endcase
        if (sink_run && o_out_valid && i_out_ready) begin
            if (joint_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                t_out e;
                e = joint_queue.pop_front();
                if (e.joint_dx !== o_out_data.joint_dx || e.joint_dy !== o_out_data.joint_dy
                        || e.unreachable !== o_out_data.unreachable) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp dx=%0d dy=%0d u=%b got dx=%0d dy=%0d u=%b",
                            e.joint_dx, e.joint_dy, e.unreachable, o_out_data.joint_dx,
                            o_out_data.joint_dy, o_out_data.unreachable);
                end
            end
        end
    end

    function automatic t_in make_item(input int x0, y0, x1, y1, input int a, b);
        t_in it;
        it.upper_x = x0[15:0];
        it.upper_y = y0[15:0];
        it.lower_x = x1[15:0];
        it.lower_y = y1[15:0];
        it.upper_len = a[15:0];
        it.lower_len = b[15:0];
        return it;
    endfunction

    task automatic test_directed();
        send_paced(make_item(100, 100, 100, 100, 300, 300));
        send_paced(make_item(0, 0, 1000, 0, 300, 300));
        send_paced(make_item(0, 0, 100, 0, 600, 300));
        send_paced(make_item(0, 0, 600, 0, 300, 300));
        send_paced(make_item(0, 0, 300, 0, 600, 300));
        send_paced(make_item(0, 0, 400, 300, 400, 300));
        send_paced(make_item(0, 0, 100, 0, 500, 450));
        send_paced(make_item(-32768, -32768, 32767, 32767, 65535, 65535));
        send_paced(make_item(32767, 32767, -32768, -32768, 65535, 1));
        send_paced(make_item(-32768, 0, 32767, 0, 65535, 0));
        send_paced(make_item(0, 0, 1, 0, 0, 1));
        send_paced(make_item(0, 0, 0, 1, 1, 1));
        send_paced(make_item(-32768, 32767, 32767, -32768, 40000, 40000));
        send_paced(make_item(0, 0, 0, 0, 0, 0));
        send_paced(make_item(0, 0, 3, 4, 65535, 65532));
        send_paced(make_item(5, -7, -20000, 20000, 30000, 30000));
        send_paced(make_item(0, 0, 256, 0, 65535, 65535));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (joint_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reachable(input int count);
        repeat (count) begin
            int x0, y0, ang, x1, y1, a, b, dd;
            x0 = $urandom_range(0, 65535) - 32768;
            y0 = $urandom_range(0, 65535) - 32768;
            x1 = x0 + int'($urandom_range(0, 8000)) - 4000;
            y1 = y0 + int'($urandom_range(0, 8000)) - 4000;
            if (x1 > 32767) x1 = 32767;
            if (x1 < -32768) x1 = -32768;
            if (y1 > 32767) y1 = 32767;
            if (y1 < -32768) y1 = -32768;
            dd = int'(int_sqrt(longint'(x1 - x0) * (x1 - x0) + longint'(y1 - y0) * (y1 - y0)));
            a = $urandom_range(dd / 2 + 1, dd + 2000);
            ang = (a > dd) ? a - dd : dd - a;
            b = $urandom_range(ang + 1, a + dd);
            if (b > 65535) b = 65535;
            send_paced(make_item(x0, y0, x1, y1, a, b));
        end
    endtask

    task automatic test_noise(input int count);
        repeat (count) begin
            t_in it;
            it = t_in'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 1)) it.upper_len = it.upper_len >> $urandom_range(0, 15);
            send_paced(it);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sink_run = 1'b1;
        test_directed();
        stall_mode = 1;
        test_reachable(500);
        wait_drained();
        repeat (20) @(posedge i_clk);
        stall_mode = 2;
        test_noise(300);
        stall_mode = 3;
        test_reachable(400);
        stall_mode = 0;
        test_noise(200);
        test_reachable(250);
        wait_drained();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
sv/tlj_pkg.sv
sv/tlj_sqrt_cell.sv
sv/tlj_div_cell.sv
sv/two_link_joint_solver.sv
dv/tb_two_link_joint_solver.sv
